// File: hdl/lrs_pkg.sv
// Package for the linear ranking sampler: fixed-point widths, register codes,
// Q16 conversion helpers and the controller/datapath command and status types.
// Depends on nothing; every module of the block imports it.
package lrs_pkg;

    localparam int MAX_POPULATION = 64;
    localparam int FRAC_BITS      = 16;

    localparam int POP_W  = 7;
    localparam int RANK_W = 6;
    localparam int ETA_W  = 18;
    localparam int OFS_W  = 16;
    localparam int IDX_W  = 8;
    localparam int DATA_W = 18;

    localparam int E_W    = FRAC_BITS + 2;
    localparam int BNP_W  = E_W + POP_W;
    localparam int SCL_W  = FRAC_BITS + 14;
    localparam int DCNT_W = $clog2(E_W + 1);
    localparam int UP_SH  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int DN_SH  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

    localparam logic [E_W-1:0]   ONE     = E_W'(1) << FRAC_BITS;
    localparam logic [E_W-1:0]   TWO     = E_W'(2) << FRAC_BITS;
    localparam logic [ETA_W-1:0] ETA_LO  = 18'h10000;
    localparam logic [ETA_W-1:0] ETA_HI  = 18'h20000;

    localparam logic [POP_W-1:0] POP_RESET    = 7'd32;
    localparam logic [POP_W-1:0] MU_RESET     = 7'd32;
    localparam logic [ETA_W-1:0] ETA_RESET    = 18'd72090;
    localparam logic             SCHEME_RESET = 1'b0;

    localparam logic [IDX_W-1:0] CFG_POP_SIZE = 8'd0;
    localparam logic [IDX_W-1:0] CFG_MU       = 8'd1;
    localparam logic [IDX_W-1:0] CFG_ETA_MAX  = 8'd2;
    localparam logic [IDX_W-1:0] CFG_SCHEME   = 8'd3;

    typedef struct packed {
        logic load;
        logic div_step;
        logic init_ptr;
        logic mul;
        logic add;
        logic emit;
        logic next_rank;
        logic pad_emit;
    } lrs_cmd_t;

    typedef struct packed {
        logic div_done;
        logic nm_one;
        logic hit;
        logic slots_left;
        logic more_ranks;
    } lrs_status_t;

    function automatic logic [E_W-1:0] eta_to_frac(input logic [ETA_W-1:0] q);
        logic [E_W+ETA_W-1:0] wide;
        wide = (E_W + ETA_W)'(q);
        wide = (wide << UP_SH) >> DN_SH;
        return wide[E_W-1:0];
    endfunction

    function automatic logic [FRAC_BITS-1:0] ofs_to_frac(input logic [OFS_W-1:0] q);
        logic [FRAC_BITS+OFS_W-1:0] wide;
        wide = (FRAC_BITS + OFS_W)'(q);
        wide = (wide << UP_SH) >> DN_SH;
        return wide[FRAC_BITS-1:0];
    endfunction

endpackage

// File: hdl/lrs_controller.sv
// Round sequencer of the linear ranking sampler: divide, per-rank add and
// pick loop, padding. Depends on lrs_pkg; drives lrs_datapath by commands.
module lrs_controller
    import lrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  lrs_status_t status,
    output lrs_cmd_t    cmd,
    output logic        busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_ADD,
        S_EMIT,
        S_PAD
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.init_ptr = 1'b1;
                if (status.div_done || status.nm_one)
                    state_next = S_MUL;
                else
                    cmd.div_step = 1'b1;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.mul = 1'b1;
                if (status.hit)
                    cmd.emit = 1'b1;
                else if (!status.slots_left)
                    state_next = S_IDLE;
                else if (status.more_ranks)
                begin
                    cmd.next_rank = 1'b1;
                    state_next    = S_ADD;
                end
                else
                    state_next = S_PAD;
            end
            S_PAD:
            begin
                if (status.slots_left)
                    cmd.pad_emit = 1'b1;
                else
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// File: hdl/lrs_datapath.sv
// Datapath of the linear ranking sampler: configuration registers, slope
// divider, offspring accumulator, wheel pointer and result registers.
// Depends on lrs_pkg; sequenced by lrs_controller.
module lrs_datapath
    import lrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  lrs_cmd_t          cmd,
    output lrs_status_t       status,
    input  logic              cfg_valid,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0] cfg_data,
    input  logic [OFS_W-1:0]  wheel_offset,
    output logic              result_strobe,
    output logic [RANK_W-1:0] rank_index,
    output logic [RANK_W-1:0] slot_index,
    output logic              is_last
);

    logic [POP_W-1:0]     pop_cfg_reg;
    logic [POP_W-1:0]     mu_cfg_reg;
    logic [ETA_W-1:0]     eta_cfg_reg;
    logic                 scheme_cfg_reg;

    logic [POP_W-1:0]     np_reg;
    logic [POP_W-1:0]     nm_reg;
    logic                 scheme_reg;
    logic [FRAC_BITS-1:0] ptr_reg;
    logic [E_W-1:0]       num_reg;
    logic [RANK_W-1:0]    rem_reg;
    logic [DCNT_W-1:0]    div_cnt_reg;
    logic [E_W-1:0]       base_reg;
    logic [BNP_W-1:0]     bnp_reg;
    logic [SCL_W-1:0]     sum_reg;
    logic [SCL_W-1:0]     ptr_scl_reg;
    logic [RANK_W-1:0]    rank_cnt_reg;
    logic [POP_W-1:0]     slot_cnt_reg;

    logic                 strobe_reg;
    logic [RANK_W-1:0]    rank_out_reg;
    logic [RANK_W-1:0]    slot_out_reg;
    logic                 last_out_reg;

    logic [POP_W-1:0]     np_c;
    logic [POP_W-1:0]     nm_c;
    logic [ETA_W-1:0]     eq_c;
    logic [E_W-1:0]       e_c;
    logic [E_W-1:0]       base0_c;
    logic [RANK_W-1:0]    divisor_c;
    logic [RANK_W:0]      rem_sh_c;
    logic                 q_bit_c;
    logic [RANK_W:0]      rem_new_c;
    logic [FRAC_BITS+POP_W-1:0] ptr_nm_c;
    logic [BNP_W-1:0]     bnp_c;
    logic [POP_W-1:0]     slot_inc_c;
    logic [POP_W-1:0]     rank_inc_c;
    logic [POP_W-1:0]     nm_m1_c;

    always_comb
    begin
        if (pop_cfg_reg == '0)
            np_c = POP_W'(1);
        else if (pop_cfg_reg > POP_W'(MAX_POPULATION))
            np_c = POP_W'(MAX_POPULATION);
        else
            np_c = pop_cfg_reg;

        if (mu_cfg_reg == '0)
            nm_c = POP_W'(1);
        else if (mu_cfg_reg > np_c)
            nm_c = np_c;
        else
            nm_c = mu_cfg_reg;

        if (eta_cfg_reg < ETA_LO)
            eq_c = ETA_LO;
        else if (eta_cfg_reg > ETA_HI)
            eq_c = ETA_HI;
        else
            eq_c = eta_cfg_reg;

        e_c = eta_to_frac(eq_c);

        if (nm_c == POP_W'(1))
            base0_c = ONE;
        else if (scheme_cfg_reg)
            base0_c = TWO - e_c;
        else
            base0_c = e_c;
    end

    assign nm_m1_c    = nm_reg - POP_W'(1);
    assign divisor_c  = nm_m1_c[RANK_W-1:0];
    assign rem_sh_c   = {rem_reg, num_reg[E_W-1]};
    assign q_bit_c    = (rem_sh_c >= {1'b0, divisor_c});
    assign rem_new_c  = q_bit_c ? (rem_sh_c - {1'b0, divisor_c}) : rem_sh_c;
    assign ptr_nm_c   = ptr_reg * nm_reg;
    assign bnp_c      = base_reg * np_reg;
    assign slot_inc_c = slot_cnt_reg + POP_W'(1);
    assign rank_inc_c = {1'b0, rank_cnt_reg} + POP_W'(1);

    always_comb
    begin
        status.div_done   = (div_cnt_reg == DCNT_W'(E_W));
        status.nm_one     = (nm_reg == POP_W'(1));
        status.slots_left = (slot_cnt_reg < np_reg);
        status.hit        = status.slots_left && (sum_reg > ptr_scl_reg);
        status.more_ranks = (rank_inc_c < nm_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop_cfg_reg    <= POP_RESET;
            mu_cfg_reg     <= MU_RESET;
            eta_cfg_reg    <= ETA_RESET;
            scheme_cfg_reg <= SCHEME_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_POP_SIZE: pop_cfg_reg    <= cfg_data[POP_W-1:0];
                CFG_MU:       mu_cfg_reg     <= cfg_data[POP_W-1:0];
                CFG_ETA_MAX:  eta_cfg_reg    <= cfg_data[ETA_W-1:0];
                CFG_SCHEME:   scheme_cfg_reg <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg  <= '0;
            rank_cnt_reg <= '0;
            slot_cnt_reg <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit || cmd.pad_emit;
            if (cmd.load)
            begin
                div_cnt_reg  <= '0;
                rank_cnt_reg <= '0;
                slot_cnt_reg <= '0;
            end
            else
            begin
                if (cmd.div_step)
                    div_cnt_reg <= div_cnt_reg + DCNT_W'(1);
                if (cmd.next_rank)
                    rank_cnt_reg <= rank_inc_c[RANK_W-1:0];
                if (cmd.emit || cmd.pad_emit)
                    slot_cnt_reg <= slot_inc_c;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            np_reg     <= np_c;
            nm_reg     <= nm_c;
            scheme_reg <= scheme_cfg_reg;
            ptr_reg    <= ofs_to_frac(wheel_offset);
            num_reg    <= (e_c - ONE) << 1;
            rem_reg    <= '0;
            base_reg   <= base0_c;
            sum_reg    <= '0;
        end
        if (cmd.div_step)
        begin
            num_reg <= {num_reg[E_W-2:0], q_bit_c};
            rem_reg <= rem_new_c[RANK_W-1:0];
        end
        if (cmd.init_ptr)
            ptr_scl_reg <= SCL_W'(ptr_nm_c);
        if (cmd.mul)
            bnp_reg <= bnp_c;
        if (cmd.add)
        begin
            sum_reg  <= sum_reg + SCL_W'(bnp_reg);
            base_reg <= scheme_reg ? (base_reg + num_reg) : (base_reg - num_reg);
        end
        if (cmd.emit)
            ptr_scl_reg <= ptr_scl_reg + (SCL_W'(nm_reg) << FRAC_BITS);
        if (cmd.emit || cmd.pad_emit)
        begin
            rank_out_reg <= cmd.emit ? rank_cnt_reg : nm_m1_c[RANK_W-1:0];
            slot_out_reg <= slot_cnt_reg[RANK_W-1:0];
            last_out_reg <= (slot_inc_c == np_reg);
        end
    end

    assign result_strobe = strobe_reg;
    assign rank_index    = rank_out_reg;
    assign slot_index    = slot_out_reg;
    assign is_last       = last_out_reg;

endmodule

// File: hdl/linear_ranking_sampler.sv
// Top level of the linear ranking sampler with stochastic universal sampling.
// Depends on lrs_pkg, lrs_controller and lrs_datapath.
//
// channel   direction  handshake                      beat
// --------  ---------  -----------------------------  ----------------------------------
// command   in         start && !busy                 wheel_offset
// result    out        result_strobe, one cycle       rank_index, slot_index, is_last
// config    in         cfg_valid && cfg_ready         cfg_index, cfg_data
//
// A round runs the bit-serial slope divider (no divide steps when mu is 1), then the
// accumulate loop, which adds up each rank and makes its picks, then pads the slots
// that are left. Results leave through output registers in the cycle after each pick;
// the receiver cannot stall, so the block never waits on it. Reset restores the register
// defaults and returns the sequencer to idle. Config beats are always taken.
module linear_ranking_sampler
    import lrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OFS_W-1:0]  wheel_offset,
    output logic              result_strobe,
    output logic [RANK_W-1:0] rank_index,
    output logic [RANK_W-1:0] slot_index,
    output logic              is_last,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0] cfg_data
);

    lrs_cmd_t    cmd;
    lrs_status_t status;

    assign cfg_ready = 1'b1;

    lrs_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    lrs_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .wheel_offset  (wheel_offset),
        .result_strobe (result_strobe),
        .rank_index    (rank_index),
        .slot_index    (slot_index),
        .is_last       (is_last)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted round did not raise busy");

    a_mid_round_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !is_last |-> busy)
        else $error("round ended before its last pick");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && is_last |=> !result_strobe)
        else $error("pick right after the last pick of a round");

    a_one_pick: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.emit, cmd.pad_emit, cmd.add, cmd.load}))
        else $error("conflicting datapath commands");

endmodule
